// File: hw/rtl/quaternion_between_vectors_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion between vectors block
// Clocked implications with a synchronous active-low reset as disable.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_BETWEEN_VECTORS_MACROS_SVH
`define QUATERNION_BETWEEN_VECTORS_MACROS_SVH

// same-cycle implication
`define QBV_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qbv check failed");

// next-cycle implication
`define QBV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qbv check failed");

`endif

// File: hw/rtl/qbv_pkg.sv
// ---------------------------------------------------------------------------
// qbv_pkg
// Widths and fixed-point constants shared by the quaternion datapath.
// ---------------------------------------------------------------------------
package qbv_pkg;

  localparam int CompW     = 16;              // input component width
  localparam int FracBits  = 14;              // output Q1.14
  localparam int OutW      = FracBits + 2;
  localparam int UnitBits  = 30;              // unit vectors in Q30
  localparam int MagW      = UnitBits + 1;    // normalized magnitude
  localparam int L2W       = 64;              // sum of squares
  localparam int LenW      = L2W / 2;
  localparam int UNumW     = 62;
  localparam int UQW       = 31;
  localparam int UW        = 32;              // signed Q30 unit component
  localparam int PW        = 64;              // Q60 products
  localparam int FNumW     = 63;
  localparam int FDenW     = LenW + UnitBits - FracBits;
  localparam int FQW       = 21;
  localparam int DefSqrtSteps = 2;
  localparam int DefDivSteps  = 2;

  localparam logic [63:0] One60    = 64'd1 << 60;
  localparam logic [63:0] OppThr   = One60 - One60 / 1000;
  localparam logic [63:0] AxisThr  = One60 / 100;
  localparam logic [OutW-1:0] QOne = OutW'(1) << FracBits;

endpackage

// File: hw/rtl/qbv_sqrt.sv
// ---------------------------------------------------------------------------
// qbv_sqrt
// Pipelined integer square root, floor(sqrt(x)), a few bit steps per stage.
// ---------------------------------------------------------------------------
module qbv_sqrt #(
  parameter int IN_W   = 64,
  parameter int STEPS  = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);
  import qbv_pkg::*;

  localparam int Iter = IN_W / 2;
  localparam int NS   = (Iter + STEPS - 1) / STEPS;

  logic [IN_W-1:0]   rem_d   [NS];
  logic [IN_W-1:0]   res_d   [NS];
  logic [IN_W-1:0]   rem_nxt [NS];
  logic [IN_W-1:0]   res_nxt [NS];
  logic [IN_W-1:0]   rem_r   [NS];
  logic [IN_W-1:0]   res_r   [NS];
  logic [SIDE_W-1:0] side_d  [NS];
  logic [SIDE_W-1:0] side_r  [NS];
  logic              vld_d   [NS];
  logic              vld_r   [NS];

  assign rem_d[0]  = in_val;
  assign res_d[0]  = '0;
  assign side_d[0] = in_side;
  assign vld_d[0]  = in_valid;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign rem_d[s]  = rem_r[s-1];
      assign res_d[s]  = res_r[s-1];
      assign side_d[s] = side_r[s-1];
      assign vld_d[s]  = vld_r[s-1];
    end

    always_comb begin
      logic [IN_W-1:0] v;
      logic [IN_W-1:0] r;
      logic [IN_W-1:0] b;
      int k;
      v = rem_d[s];
      r = res_d[s];
      for (int j = 0; j < STEPS; j++) begin
        k = s * STEPS + j;
        if (k < Iter) begin
          b = IN_W'(1) << (IN_W - 2 - 2 * k);
          if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
      end
      rem_nxt[s] = v;
      res_nxt[s] = r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_d[s];
      end
      if (en) begin
        rem_r[s]  <= rem_nxt[s];
        res_r[s]  <= res_nxt[s];
        side_r[s] <= side_d[s];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = res_r[NS-1][Iter-1:0];
  assign out_side  = side_r[NS-1];

endmodule

// File: hw/rtl/qbv_div.sv
// ---------------------------------------------------------------------------
// qbv_div
// Pipelined restoring divider, several lanes over one shared divisor.
// ---------------------------------------------------------------------------
module qbv_div #(
  parameter int NUM_W  = 62,
  parameter int DEN_W  = 32,
  parameter int QW     = 31,
  parameter int LANES  = 3,
  parameter int STEPS  = 2,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]            in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    out_quo,
  output logic [SIDE_W-1:0]           out_side
);
  import qbv_pkg::*;

  // numerator must be below den << QW
  localparam int RW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
  localparam int NS = (QW + STEPS - 1) / STEPS;

  logic [LANES-1:0][RW-1:0] rem_d   [NS];
  logic [LANES-1:0][RW-1:0] rem_nxt [NS];
  logic [LANES-1:0][RW-1:0] rem_r   [NS];
  logic [LANES-1:0][QW-1:0] quo_d   [NS];
  logic [LANES-1:0][QW-1:0] quo_nxt [NS];
  logic [LANES-1:0][QW-1:0] quo_r   [NS];
  logic [DEN_W-1:0]         den_d   [NS];
  logic [DEN_W-1:0]         den_r   [NS];
  logic [SIDE_W-1:0]        side_d  [NS];
  logic [SIDE_W-1:0]        side_r  [NS];
  logic                     vld_d   [NS];
  logic                     vld_r   [NS];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign rem_d[0][l] = RW'(in_num[l]);
  end
  assign quo_d[0]  = '0;
  assign den_d[0]  = in_den;
  assign side_d[0] = in_side;
  assign vld_d[0]  = in_valid;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign rem_d[s]  = rem_r[s-1];
      assign quo_d[s]  = quo_r[s-1];
      assign den_d[s]  = den_r[s-1];
      assign side_d[s] = side_r[s-1];
      assign vld_d[s]  = vld_r[s-1];
    end

    always_comb begin
      logic [RW-1:0] t;
      int k;
      rem_nxt[s] = rem_d[s];
      quo_nxt[s] = quo_d[s];
      for (int j = 0; j < STEPS; j++) begin
        k = s * STEPS + j;
        if (k < QW) begin
          t = RW'(den_d[s]) << (QW - 1 - k);
          for (int l = 0; l < LANES; l++) begin
            if (rem_nxt[s][l] >= t) begin
              rem_nxt[s][l] = rem_nxt[s][l] - t;
              quo_nxt[s][l][QW-1-k] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_d[s];
      end
      if (en) begin
        rem_r[s]  <= rem_nxt[s];
        quo_r[s]  <= quo_nxt[s];
        den_r[s]  <= den_d[s];
        side_r[s] <= side_d[s];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_quo   = quo_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// File: hw/rtl/quaternion_between_vectors.sv
// ---------------------------------------------------------------------------
// quaternion_between_vectors
// Unit quaternion turning a source 3-vector onto a destination 3-vector.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  in_     | in  | start_x,y,z, dest_x,y,z (16b each)     | -
//  out_    | out | quat_w,x,y,z (16b each, Q1.14)         | opposite_case, degenerate_input
//
//  One pair per cycle while the output is not stalled; each pair passes the
//  four root/divide pipelines in series (root, divide, root, divide), two bit steps per stage.
//  All stages advance together; a stall at the output holds the whole pipe.
//  Reset clears the valid bits only.
// ---------------------------------------------------------------------------
module quaternion_between_vectors #(
  parameter int SQRT_STEPS = qbv_pkg::DefSqrtSteps,
  parameter int DIV_STEPS  = qbv_pkg::DefDivSteps
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // start_x, start_y, start_z, dest_x, dest_y, dest_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic [1:0]  out_tuser   // opposite_case, degenerate_input
);
  import qbv_pkg::*;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: magnitude and normalizing shift
  logic [1:0][2:0][16:0]     s1_abs;
  logic [1:0][2:0]           s1_neg_nxt;
  logic [1:0][2:0][MagW-1:0] s1_mag_nxt;
  logic [1:0]                s1_zero_nxt;
  logic [1:0][2:0][MagW-1:0] s1_mag_r;
  logic [1:0][2:0]           s1_neg_r;
  logic [1:0]                s1_zero_r;
  logic                      s1_vld_r;

  always_comb begin
    logic signed [16:0] cx;
    logic [16:0] m;
    logic [4:0]  msb;
    logic [4:0]  sh;
    for (int v = 0; v < 2; v++) begin
      m = '0;
      for (int i = 0; i < 3; i++) begin
        cx = {in_tdata[(v*3+i)*CompW + CompW-1], in_tdata[(v*3+i)*CompW +: CompW]};
        s1_neg_nxt[v][i] = cx[16];
        s1_abs[v][i] = cx[16] ? 17'(-cx) : 17'(cx);
        if (s1_abs[v][i] > m) m = s1_abs[v][i];
      end
      msb = '0;
      for (int b = 0; b < 17; b++) begin
        if (m[b]) msb = 5'(b);
      end
      sh = 5'd30 - msb;
      s1_zero_nxt[v] = (m == '0);
      for (int i = 0; i < 3; i++) begin
        s1_mag_nxt[v][i] = MagW'(s1_abs[v][i]) << sh;
      end
    end
  end

  // ---------------- stage 2: squares, stage 3: sum
  logic [1:0][2:0][61:0]     s2_sq_r;
  logic [1:0][2:0][MagW-1:0] s2_mag_r;
  logic [1:0][2:0]           s2_neg_r;
  logic [1:0]                s2_zero_r;
  logic                      s2_vld_r;
  logic [1:0][L2W-1:0]       s3_l2_r;
  logic [1:0][2:0][MagW-1:0] s3_mag_r;
  logic [1:0][2:0]           s3_neg_r;
  logic [1:0]                s3_zero_r;
  logic                      s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      s1_mag_r  <= s1_mag_nxt;
      s1_neg_r  <= s1_neg_nxt;
      s1_zero_r <= s1_zero_nxt;
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          s2_sq_r[v][i] <= 62'(s1_mag_r[v][i]) * 62'(s1_mag_r[v][i]);
        end
        s3_l2_r[v] <= L2W'(s2_sq_r[v][0]) + L2W'(s2_sq_r[v][1]) + L2W'(s2_sq_r[v][2]);
      end
      s2_mag_r  <= s1_mag_r;
      s2_neg_r  <= s1_neg_r;
      s2_zero_r <= s1_zero_r;
      s3_mag_r  <= s2_mag_r;
      s3_neg_r  <= s2_neg_r;
      s3_zero_r <= s2_zero_r;
    end
  end

  // ---------------- vector lengths
  localparam int LSideW = 1 + 3 + 3 * MagW;
  logic [1:0]             ln_vld;
  logic [1:0][LenW-1:0]   ln_len;
  logic [1:0][LSideW-1:0] ln_side;

  for (genvar v = 0; v < 2; v++) begin : g_len
    qbv_sqrt #(
      .IN_W(L2W), .STEPS(SQRT_STEPS), .SIDE_W(LSideW)
    ) u_len (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(s3_vld_r), .in_val(s3_l2_r[v]),
      .in_side({s3_zero_r[v], s3_neg_r[v], s3_mag_r[v]}),
      .out_valid(ln_vld[v]), .out_root(ln_len[v]), .out_side(ln_side[v])
    );
  end

  // ---------------- stage 4: rounded dividends for the unit vectors
  logic [1:0][2:0][UNumW-1:0] s4_num_r;
  logic [1:0][LenW-1:0]       s4_den_r;
  logic [1:0][3:0]            s4_side_r;
  logic                       s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= ln_vld[0] & ln_vld[1];
    end
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          s4_num_r[v][i] <= (UNumW'(ln_side[v][i*MagW +: MagW]) << UnitBits)
                          + UNumW'(ln_len[v] >> 1);
        end
        s4_den_r[v]  <= ln_len[v];
        s4_side_r[v] <= ln_side[v][LSideW-1 -: 4];
      end
    end
  end

  logic [1:0]                un_vld;
  logic [1:0][2:0][UQW-1:0]  un_quo;
  logic [1:0][3:0]           un_side;

  for (genvar v = 0; v < 2; v++) begin : g_unit
    qbv_div #(
      .NUM_W(UNumW), .DEN_W(LenW), .QW(UQW), .LANES(3),
      .STEPS(DIV_STEPS), .SIDE_W(4)
    ) u_unit (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(s4_vld_r), .in_num(s4_num_r[v]), .in_den(s4_den_r[v]),
      .in_side(s4_side_r[v]),
      .out_valid(un_vld[v]), .out_quo(un_quo[v]), .out_side(un_side[v])
    );
  end

  // ---------------- stage 5: signed unit vectors
  logic signed [UW-1:0] s5_a_r [3];
  logic signed [UW-1:0] s5_b_r [3];
  logic                 s5_deg_r;
  logic                 s5_vld_r;

  // ---------------- stage 6: products, stage 7: dot, cross, axis lengths
  logic signed [PW-1:0] s6_p_r  [3][3];
  logic signed [PW-1:0] s6_sa_r [3];
  logic signed [UW-1:0] s6_a_r  [3];
  logic                 s6_deg_r;
  logic                 s6_vld_r;
  logic signed [PW-1:0] s7_dot_r;
  logic signed [PW-1:0] s7_cr_r [3];
  logic [PW-1:0]        s7_l2a_r;
  logic [PW-1:0]        s7_l2b_r;
  logic signed [UW-1:0] s7_a_r  [3];
  logic                 s7_deg_r;
  logic                 s7_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= un_vld[0] & un_vld[1];
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_a_r[i] <= un_side[0][i] ? -$signed({1'b0, un_quo[0][i]})
                                   :  $signed({1'b0, un_quo[0][i]});
        s5_b_r[i] <= un_side[1][i] ? -$signed({1'b0, un_quo[1][i]})
                                   :  $signed({1'b0, un_quo[1][i]});
        for (int j = 0; j < 3; j++) begin
          s6_p_r[i][j] <= s5_a_r[i] * s5_b_r[j];
        end
        s6_sa_r[i] <= s5_a_r[i] * s5_a_r[i];
      end
      s5_deg_r <= un_side[0][3] | un_side[1][3];
      s6_a_r   <= s5_a_r;
      s6_deg_r <= s5_deg_r;
      s7_dot_r   <= s6_p_r[0][0] + s6_p_r[1][1] + s6_p_r[2][2];
      s7_cr_r[0] <= s6_p_r[1][2] - s6_p_r[2][1];
      s7_cr_r[1] <= s6_p_r[2][0] - s6_p_r[0][2];
      s7_cr_r[2] <= s6_p_r[0][1] - s6_p_r[1][0];
      s7_l2a_r   <= PW'(s6_sa_r[0] + s6_sa_r[1]);
      s7_l2b_r   <= PW'(s6_sa_r[1] + s6_sa_r[2]);
      s7_a_r     <= s6_a_r;
      s7_deg_r   <= s6_deg_r;
    end
  end

  // ---------------- stage 8: branch select and root operand
  localparam int FSideW = 2 + 3 * PW + 3 * UW;
  logic                 s8_opp_nxt;
  logic                 s8_axa;
  logic [L2W-1:0]       s8_op_nxt;
  logic [UW-1:0]        s8_ax_nxt [3];
  logic [L2W-1:0]       s8_op_r;
  logic [FSideW-1:0]    s8_side_r;
  logic                 s8_vld_r;

  always_comb begin
    s8_opp_nxt = !s7_deg_r && (s7_dot_r < -$signed(OppThr));
    s8_axa     = s7_l2a_r >= AxisThr;
    if (s8_axa) begin
      s8_ax_nxt[0] = UW'(-s7_a_r[1]);
      s8_ax_nxt[1] = UW'(s7_a_r[0]);
      s8_ax_nxt[2] = '0;
    end else begin
      s8_ax_nxt[0] = '0;
      s8_ax_nxt[1] = UW'(-s7_a_r[2]);
      s8_ax_nxt[2] = UW'(s7_a_r[1]);
    end
    if (s8_opp_nxt) begin
      s8_op_nxt = s8_axa ? s7_l2a_r : s7_l2b_r;
    end else begin
      s8_op_nxt = L2W'(s7_dot_r + $signed(One60)) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s8_vld_r <= s7_vld_r;
    end
    if (en) begin
      s8_op_r   <= s8_op_nxt;
      s8_side_r <= {s7_deg_r, s8_opp_nxt,
                    s7_cr_r[2], s7_cr_r[1], s7_cr_r[0],
                    s8_ax_nxt[2], s8_ax_nxt[1], s8_ax_nxt[0]};
    end
  end

  logic              rt_vld;
  logic [LenW-1:0]   rt_root;
  logic [FSideW-1:0] rt_side;

  qbv_sqrt #(
    .IN_W(L2W), .STEPS(SQRT_STEPS), .SIDE_W(FSideW)
  ) u_root (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s8_vld_r), .in_val(s8_op_r), .in_side(s8_side_r),
    .out_valid(rt_vld), .out_root(rt_root), .out_side(rt_side)
  );

  // ---------------- stage 9: final dividends, divisor and w
  localparam int QSideW = 2 + 3 + OutW;
  logic                  rt_opp;
  logic                  rt_deg;
  logic [FDenW-1:0]      s9_den_nxt;
  logic [2:0][FNumW-1:0] s9_num_nxt;
  logic [2:0]            s9_sgn_nxt;
  logic [OutW-1:0]       s9_w_nxt;
  logic [FDenW-1:0]      s9_den_r;
  logic [2:0][FNumW-1:0] s9_num_r;
  logic [QSideW-1:0]     s9_side_r;
  logic                  s9_vld_r;

  assign rt_deg = rt_side[FSideW-1];
  assign rt_opp = rt_side[FSideW-2];

  always_comb begin
    logic signed [PW-1:0] cr;
    logic signed [UW-1:0] ax;
    logic [PW-1:0]        crm;
    logic [UW-1:0]        axm;
    s9_den_nxt = rt_opp ? FDenW'(rt_root) : (FDenW'(rt_root) << (UnitBits - FracBits));
    for (int i = 0; i < 3; i++) begin
      cr  = $signed(rt_side[3*UW + i*PW +: PW]);
      ax  = $signed(rt_side[i*UW +: UW]);
      crm = cr[PW-1] ? PW'(-cr) : PW'(cr);
      axm = ax[UW-1] ? UW'(-ax) : UW'(ax);
      if (rt_opp) begin
        s9_num_nxt[i] = (FNumW'(axm) << FracBits) + FNumW'(rt_root >> 1);
        s9_sgn_nxt[i] = ax[UW-1];
      end else begin
        s9_num_nxt[i] = FNumW'(crm) + FNumW'(s9_den_nxt >> 1);
        s9_sgn_nxt[i] = cr[PW-1];
      end
    end
    s9_w_nxt = rt_opp ? '0
             : OutW'((33'(rt_root) + (33'(1) << (30 - FracBits))) >> (31 - FracBits));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else if (en) begin
      s9_vld_r <= rt_vld;
    end
    if (en) begin
      s9_den_r  <= s9_den_nxt;
      s9_num_r  <= s9_num_nxt;
      s9_side_r <= {rt_deg, rt_opp, s9_sgn_nxt, s9_w_nxt};
    end
  end

  logic                dq_vld;
  logic [2:0][FQW-1:0] dq_quo;
  logic [QSideW-1:0]   dq_side;

  qbv_div #(
    .NUM_W(FNumW), .DEN_W(FDenW), .QW(FQW), .LANES(3),
    .STEPS(DIV_STEPS), .SIDE_W(QSideW)
  ) u_quat (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s9_vld_r), .in_num(s9_num_r), .in_den(s9_den_r), .in_side(s9_side_r),
    .out_valid(dq_vld), .out_quo(dq_quo), .out_side(dq_side)
  );

  // ---------------- stage 10: clamp, sign, degenerate override
  logic [3:0][OutW-1:0] q_nxt;
  logic [3:0][OutW-1:0] q_r;
  logic                 opp_r;
  logic                 deg_r;
  logic                 vld_out_r;
  logic                 dq_deg;
  logic                 dq_opp;

  assign dq_deg = dq_side[QSideW-1];
  assign dq_opp = dq_side[QSideW-2];

  always_comb begin
    logic [OutW-1:0] mag;
    q_nxt[0] = (dq_side[OutW-1:0] > QOne) ? QOne : dq_side[OutW-1:0];
    for (int i = 0; i < 3; i++) begin
      mag = (dq_quo[i] > FQW'(QOne)) ? QOne : OutW'(dq_quo[i]);
      q_nxt[i+1] = dq_side[OutW + i] ? (OutW'(0) - mag) : mag;
    end
    if (dq_deg) begin
      q_nxt = '0;
      q_nxt[0] = QOne;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= dq_vld;
    end
    if (en) begin
      q_r   <= q_nxt;
      opp_r <= dq_opp & !dq_deg;
      deg_r <= dq_deg;
    end
  end

  assign out_tvalid = vld_out_r;
  assign out_tdata  = q_r;
  assign out_tuser  = {deg_r, opp_r};

endmodule

// File: hw/rtl/qbv_checker.sv
// ---------------------------------------------------------------------------
// qbv_checker
// Port-level checks on the quaternion block, bound to the top level.
// ---------------------------------------------------------------------------
`include "quaternion_between_vectors_macros.svh"

module qbv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import qbv_pkg::*;

  // a held result request stays put
  `QBV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // the input only backs up when the output is stalled
  `QBV_ASSERT_NOW(a_in_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready)
  // zero-length input gives the identity and never the opposite flag
  `QBV_ASSERT_NOW(a_degen, clk, rst_n, out_tvalid && out_tuser[1],
                  out_tdata == {48'd0, QOne} && !out_tuser[0])
  // half-turn results have no scalar part
  `QBV_ASSERT_NOW(a_opp_w, clk, rst_n, out_tvalid && out_tuser[0],
                  out_tdata[15:0] == 16'd0)

endmodule

bind quaternion_between_vectors qbv_checker u_qbv_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
